FILE: src/itl_pkg.sv
package itl_pkg;

  // operation codes
  localparam logic OP_SCAN      = 1'b0;
  localparam logic OP_TRANSFORM = 1'b1;

  // register indexes
  localparam logic [2:0] REG_TINT_RED      = 3'd0;
  localparam logic [2:0] REG_TINT_GREEN    = 3'd1;
  localparam logic [2:0] REG_TINT_BLUE     = 3'd2;
  localparam logic [2:0] REG_MASK_OPACITY  = 3'd3;
  localparam logic [2:0] REG_ALPHA_PRESENT = 3'd4;

  // rec.709 weights, q16, summing to 65536
  localparam logic [15:0] LUMA_WR = 16'd13933;
  localparam logic [15:0] LUMA_WG = 16'd46871;
  localparam logic [15:0] LUMA_WB = 16'd4732;

  // full-scale luminance 255 * 65536, and half of it for rounding
  localparam logic [23:0] LUMA_FULL = 24'd16711680;
  localparam logic [31:0] LUMA_HALF = 32'd8355840;

  // rounding offset for alpha * opacity / 255
  localparam logic [15:0] ALPHA_HALF = 16'd127;

  // reciprocal of 255 in q16 (underestimates by at most one)
  localparam logic [8:0] RECIP_255 = 9'd257;
  localparam logic [8:0] DIV_255   = 9'd255;

  localparam int LANES = 4;

  typedef struct packed {
    logic       operation;
    logic       first;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } pixel_out_t;

  typedef struct packed {
    logic [7:0] tint_red;
    logic [7:0] tint_green;
    logic [7:0] tint_blue;
    logic [7:0] mask_opacity;
    logic       alpha_present;
  } cfg_t;

  typedef struct packed {
    logic       seen;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } front_t;

  typedef struct packed {
    logic [23:0] lum;
    logic [15:0] alpha_prod;
    logic [7:0]  alpha;
  } luma_t;

  // lanes 0..2 red, green, blue; lane 3 alpha product
  typedef struct packed {
    logic [LANES-1:0][15:0] dividend;
    logic [7:0]             alpha;
  } scaled_t;

  typedef struct packed {
    logic [LANES-1:0][8:0] q_est;
    logic [LANES-1:0][8:0] rem;
    logic [7:0]            alpha;
  } quot_t;

endpackage

FILE: src/itl_luma.sv
module itl_luma (
  input  logic                clk,
  input  logic                rst,
  input  itl_pkg::cfg_t       cfg,
  input  logic                up_valid,
  output logic                up_ready,
  input  itl_pkg::front_t     up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output itl_pkg::luma_t      dn_data
);

  logic [23:0]    lum_sum;
  itl_pkg::luma_t stage_next;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    lum_sum = {8'd0, itl_pkg::LUMA_WR} * {16'd0, up_data.red}
            + {8'd0, itl_pkg::LUMA_WG} * {16'd0, up_data.green}
            + {8'd0, itl_pkg::LUMA_WB} * {16'd0, up_data.blue};
    // no visible color in the image: intensity counts as one
    stage_next.lum        = up_data.seen ? lum_sum : itl_pkg::LUMA_FULL;
    stage_next.alpha_prod = {8'd0, up_data.alpha} * {8'd0, cfg.mask_opacity}
                          + itl_pkg::ALPHA_HALF;
    stage_next.alpha      = up_data.alpha;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= stage_next;
    end
  end

endmodule

FILE: src/itl_scale.sv
module itl_scale (
  input  logic                clk,
  input  logic                rst,
  input  itl_pkg::cfg_t       cfg,
  input  logic                up_valid,
  output logic                up_ready,
  input  itl_pkg::luma_t      up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output itl_pkg::scaled_t    dn_data
);

  logic [2:0][7:0]  mask;
  logic [2:0][31:0] prod;
  itl_pkg::scaled_t stage_next;

  assign up_ready = !dn_valid || dn_ready;
  assign mask = {cfg.tint_blue, cfg.tint_green, cfg.tint_red};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // m * lum + d/2, then the power-of-two part of d comes off as a shift
      prod[i] = {24'd0, mask[i]} * {8'd0, up_data.lum} + itl_pkg::LUMA_HALF;
      stage_next.dividend[i] = prod[i][31:16];
    end
    stage_next.dividend[3] = up_data.alpha_prod;
    stage_next.alpha       = up_data.alpha;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= stage_next;
    end
  end

endmodule

FILE: src/itl_div255.sv
module itl_div255 (
  input  logic                 clk,
  input  logic                 rst,
  input  itl_pkg::cfg_t        cfg,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  itl_pkg::scaled_t     up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output itl_pkg::pixel_out_t  dn_data
);

  localparam int LANES = itl_pkg::LANES;

  logic                 est_valid;
  logic                 est_ready;
  itl_pkg::quot_t       est;
  itl_pkg::quot_t       est_next;
  logic [LANES-1:0][24:0] recip_prod;
  logic [LANES-1:0][16:0] back_prod;
  logic [LANES-1:0][16:0] rem_full;
  logic [LANES-1:0][7:0]  quot;
  itl_pkg::pixel_out_t  out_next;

  assign up_ready  = !est_valid || est_ready;
  assign est_ready = !dn_valid || dn_ready;

  // first step: reciprocal estimate and its remainder
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      recip_prod[i]     = {9'd0, up_data.dividend[i]} * {16'd0, itl_pkg::RECIP_255};
      est_next.q_est[i] = recip_prod[i][24:16];
      back_prod[i]      = {8'd0, est_next.q_est[i]} * {8'd0, itl_pkg::DIV_255};
      rem_full[i]       = {1'b0, up_data.dividend[i]} - back_prod[i];
      est_next.rem[i]   = rem_full[i][8:0];
    end
    est_next.alpha = up_data.alpha;
  end

  // second step: one correction, quotient stays within a byte
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      quot[i] = est.q_est[i][7:0] + {7'd0, (est.rem[i] >= itl_pkg::DIV_255)};
    end
    out_next.out_red   = quot[0];
    out_next.out_green = quot[1];
    out_next.out_blue  = quot[2];
    out_next.out_alpha = cfg.alpha_present ? quot[3] : est.alpha;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      est_valid <= 1'b0;
      dn_valid  <= 1'b0;
    end else begin
      if (up_ready) begin
        est_valid <= up_valid;
      end
      if (est_ready) begin
        dn_valid <= est_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      est <= est_next;
    end
    if (est_ready && est_valid) begin
      dn_data <= out_next;
    end
  end

endmodule

FILE: src/icon_luminance_tint.sv
// luminance-preserving tint of rgba pixels with a programmable mask color
//
// pixel channel (pix_valid / pix_ready / pix_data): one pixel per transfer.
//   operation scan only updates the visible-color flag (first clears it
//   beforehand) and produces no result. operation transform produces one
//   result on the res channel (res_valid / res_ready / res_data).
// config port (cfg_we / cfg_index / cfg_data): register writes take effect
//   at the clock edge; write only while the pipeline is empty.
// throughput: one pixel per clock when the result side does not stall,
//   set by a five-register pipeline in which every stage advances on its
//   own (front register, luminance multiply, mask multiply, reciprocal
//   divide by 255, correction/output register); a transform result
//   reaches res_data through these registers in that order.
// stall: when res_ready is low the result holds; pix_ready stays high while
//   any earlier stage still holds a bubble, and drops only once all full.
// reset (rst, synchronous): pipeline emptied, visible-color flag cleared,
//   mask channels and opacity 255, alpha_present 1.
module icon_luminance_tint (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 pix_valid,
  output logic                 pix_ready,
  input  itl_pkg::pixel_in_t   pix_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output itl_pkg::pixel_out_t  res_data
);

  // configuration registers
  itl_pkg::cfg_t    cfg;

  // visible-color flag of the current image
  logic             seen;
  logic             seen_next;

  // front stage
  logic             front_valid;
  logic             front_ready;
  itl_pkg::front_t  front;

  logic             pix_xfer;
  logic             is_scan;
  logic             visible;
  logic             has_color;

  logic             luma_valid;
  logic             luma_ready;
  itl_pkg::luma_t   luma;
  logic             scale_valid;
  logic             scale_ready;
  itl_pkg::scaled_t scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tint_red      <= 8'd255;
      cfg.tint_green    <= 8'd255;
      cfg.tint_blue     <= 8'd255;
      cfg.mask_opacity  <= 8'd255;
      cfg.alpha_present <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        itl_pkg::REG_TINT_RED:      cfg.tint_red      <= cfg_data;
        itl_pkg::REG_TINT_GREEN:    cfg.tint_green    <= cfg_data;
        itl_pkg::REG_TINT_BLUE:     cfg.tint_blue     <= cfg_data;
        itl_pkg::REG_MASK_OPACITY:  cfg.mask_opacity  <= cfg_data;
        itl_pkg::REG_ALPHA_PRESENT: cfg.alpha_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // the front register takes a pixel whenever it is empty or moving on
  assign pix_ready = !front_valid || front_ready;
  assign pix_xfer  = pix_valid && pix_ready;
  assign is_scan   = (pix_data.operation == itl_pkg::OP_SCAN);

  // a pixel is visible if alpha is ignored or nonzero
  assign visible   = !cfg.alpha_present || (pix_data.alpha != 8'd0);
  assign has_color = (pix_data.red | pix_data.green | pix_data.blue) != 8'd0;

  always_comb begin
    seen_next = seen;
    if (pix_xfer && is_scan) begin
      seen_next = (seen && !pix_data.first) || (visible && has_color);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen        <= 1'b0;
      front_valid <= 1'b0;
    end else begin
      seen <= seen_next;
      // scan pixels end here: only transforms enter the pipeline
      if (pix_ready) begin
        front_valid <= pix_valid && !is_scan;
      end
    end
  end

  // the flag is sampled at the transfer, in stream order
  always_ff @(posedge clk) begin
    if (pix_xfer && !is_scan) begin
      front.seen  <= seen;
      front.red   <= pix_data.red;
      front.green <= pix_data.green;
      front.blue  <= pix_data.blue;
      front.alpha <= pix_data.alpha;
    end
  end

  itl_luma u_luma (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (front_valid),
    .up_ready (front_ready),
    .up_data  (front),
    .dn_valid (luma_valid),
    .dn_ready (luma_ready),
    .dn_data  (luma)
  );

  itl_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (luma_valid),
    .up_ready (luma_ready),
    .up_data  (luma),
    .dn_valid (scale_valid),
    .dn_ready (scale_ready),
    .dn_data  (scaled)
  );

  itl_div255 u_div255 (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (scale_valid),
    .up_ready (scale_ready),
    .up_data  (scaled),
    .dn_valid (res_valid),
    .dn_ready (res_ready),
    .dn_data  (res_data)
  );

`ifndef SYNTHESIS
  // a scan transfer never reaches the pipeline
  a_scan_dropped: assert property (@(posedge clk) disable iff (rst)
    (pix_xfer && is_scan) |=> !front_valid)
    else $error("scan pixel entered the pipeline");

  // a transform transfer lands in the front stage with the flag of its time
  a_transform_front: assert property (@(posedge clk) disable iff (rst)
    (pix_xfer && !is_scan) |=> (front_valid && (front.seen == $past(seen))))
    else $error("transform pixel lost or flag mismatch at front stage");

  // a first scan pixel without color leaves the flag cleared
  a_first_clears: assert property (@(posedge clk) disable iff (rst)
    (pix_xfer && is_scan && pix_data.first && !has_color) |=> !seen)
    else $error("visible-color flag not cleared by first pixel");

  // a front stage blocked by a full pipeline holds its pixel
  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    (front_valid && !front_ready) |=> (front_valid && $stable(front)))
    else $error("front stage changed while stalled");
`endif

endmodule
